@@ rtl/core/smpq_pkg.sv @@
// Package for the stable minimum priority queue.
// Holds shared constants, codes, state type and controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smpq_pkg;
    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W = 32;
    localparam int JOB_W = 16;
    localparam int TYPE_W = 8;
    localparam int OCC_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0,
        ERR_FULL = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_UP,
        ST_HEAD,
        ST_SHIFT_DOWN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic up_start;
        logic up_step;
        logic up_write;
        logic head_read;
        logic down_step;
        logic count_inc;
        logic count_dec;
        logic emit;
        logic emit_removed;
        err_t err;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic up_done;
        logic down_done;
    } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/smpq_ctrl.sv @@
// Controller state machine of the stable minimum priority queue.
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire smpq_pkg::stat_t stat,
    output smpq_pkg::cmd_t      cmd
);
    smpq_pkg::state_t state_reg;
    smpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.err = smpq_pkg::ERR_OK;
        busy = 1'b1;
        unique case (state_reg)
            smpq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = smpq_pkg::ST_SEARCH;
                end
            end
            smpq_pkg::ST_SEARCH:
            begin
                if (stat.op == smpq_pkg::OP_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.emit = 1'b1;
                        cmd.err = smpq_pkg::ERR_FULL;
                        state_next = smpq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.up_start = 1'b1;
                        state_next = smpq_pkg::ST_SHIFT_UP;
                    end
                end
                else if (stat.empty)
                begin
                    cmd.emit = 1'b1;
                    cmd.err = smpq_pkg::ERR_EMPTY;
                    state_next = smpq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.head_read = 1'b1;
                    state_next = smpq_pkg::ST_HEAD;
                end
            end
            smpq_pkg::ST_SHIFT_UP:
            begin
                if (stat.up_done)
                begin
                    cmd.up_write = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next = smpq_pkg::ST_DONE;
                end
                else
                begin
                    cmd.up_step = 1'b1;
                end
            end
            smpq_pkg::ST_HEAD:
            begin
                cmd.scan_start = 1'b1;
                state_next = smpq_pkg::ST_SHIFT_DOWN;
            end
            smpq_pkg::ST_SHIFT_DOWN:
            begin
                if (stat.down_done)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.emit_removed = 1'b1;
                    state_next = smpq_pkg::ST_DONE;
                end
                else
                begin
                    cmd.down_step = 1'b1;
                end
            end
            smpq_pkg::ST_DONE:
            begin
                cmd.emit = 1'b1;
                state_next = smpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = smpq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/smpq_dp.sv @@
// Datapath of the stable minimum priority queue: entry memory, count and result registers.
// Inserts move entries up one slot per fresh read; removes move them down one per cycle.
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpq_dp #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          operation,
    input  wire logic [smpq_pkg::TIME_W-1:0]   event_time,
    input  wire logic [smpq_pkg::JOB_W-1:0]    job_number,
    input  wire logic [smpq_pkg::TYPE_W-1:0]   event_type,
    input  wire smpq_pkg::cmd_t                cmd,
    output smpq_pkg::stat_t                    stat,
    output logic                               removed_valid,
    output logic [smpq_pkg::TIME_W-1:0]        removed_time,
    output logic [smpq_pkg::JOB_W-1:0]         removed_job,
    output logic [smpq_pkg::TYPE_W-1:0]        removed_type,
    output logic [1:0]                         error_code,
    output logic [smpq_pkg::OCC_W-1:0]         occupancy,
    output logic                               done
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = smpq_pkg::TIME_W + smpq_pkg::JOB_W + smpq_pkg::TYPE_W;

    logic [EW-1:0] mem [DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          op_reg;
    logic [EW-1:0] item_reg;
    logic [EW-1:0] rd_reg;
    logic          rd_ok_reg;
    logic [EW-1:0] head_reg;
    logic          valid_reg;
    logic [EW-1:0] out_reg;
    logic [1:0]    err_reg;
    logic          done_reg;
    logic [smpq_pkg::TIME_W-1:0] rd_time;
    logic          up_done;

    assign rd_time = rd_reg[EW-1 -: smpq_pkg::TIME_W];
    // Shift up walks from the tail down; it stops once the read entry stays in place.
    assign up_done = (idx_reg == '0) || (rd_ok_reg && rd_time <= item_reg[EW-1 -: smpq_pkg::TIME_W]);

    assign stat.op = op_reg;
    assign stat.full = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.up_done = up_done && (rd_ok_reg || idx_reg == '0);
    assign stat.down_done = (idx_reg >= count_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.up_start)
        begin
            idx_next = count_reg;
        end
        else if (cmd.up_step && rd_ok_reg)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.scan_start)
        begin
            idx_next = CW'(1);
        end
        else if (cmd.down_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.up_step && rd_ok_reg)
        begin
            mem[idx_reg[AW-1:0]] <= rd_reg;
        end
        else if (cmd.up_write)
        begin
            mem[idx_reg[AW-1:0]] <= item_reg;
        end
        else if (cmd.down_step)
        begin
            mem[AW'(idx_reg - 1'b1)] <= mem[idx_reg[AW-1:0]];
        end
        if (idx_next != '0)
        begin
            rd_reg <= mem[AW'(idx_next - 1'b1)];
        end
        if (cmd.head_read)
        begin
            head_reg <= mem[0];
        end
        if (cmd.load)
        begin
            item_reg <= {event_time, job_number, event_type};
        end
        if (cmd.emit_removed)
        begin
            out_reg <= head_reg;
        end
        else if (cmd.load)
        begin
            out_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            op_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            valid_reg <= 1'b0;
            err_reg <= smpq_pkg::ERR_OK;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            rd_ok_reg <= (cmd.up_start || (cmd.up_step && rd_ok_reg)) ? 1'b0 : 1'b1;
            if (cmd.load)
            begin
                op_reg <= operation;
                valid_reg <= 1'b0;
            end
            if (cmd.emit_removed)
            begin
                valid_reg <= 1'b1;
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            done_reg <= cmd.emit;
            err_reg <= cmd.err;
        end
    end

    assign done = done_reg;
    assign removed_valid = valid_reg && (err_reg == smpq_pkg::ERR_OK);
    assign removed_time = removed_valid ? out_reg[EW-1 -: smpq_pkg::TIME_W] : '0;
    assign removed_job = removed_valid ?
        out_reg[smpq_pkg::JOB_W+smpq_pkg::TYPE_W-1 -: smpq_pkg::JOB_W] : '0;
    assign removed_type = removed_valid ? out_reg[smpq_pkg::TYPE_W-1:0] : '0;
    assign error_code = err_reg;
    assign occupancy = smpq_pkg::OCC_W'(count_reg);
endmodule
`default_nettype wire

@@ rtl/core/stable_min_priority_queue.sv @@
// Top level of the stable minimum priority queue.
// Instantiates smpq_ctrl and smpq_dp; depends on smpq_pkg.
// An item is taken when start is high and busy low; its single result appears for one
// cycle with done high and cannot be stalled by the receiver. Entries live in a
// DEPTH-entry memory kept sorted. An insert moves each displaced entry up one slot, with a
// fresh read between moves; a remove moves entries down one slot per cycle.
`timescale 1ns / 1ps
`default_nettype none
module stable_min_priority_queue #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [smpq_pkg::TIME_W-1:0]   event_time,
    input  wire logic [smpq_pkg::JOB_W-1:0]    job_number,
    input  wire logic [smpq_pkg::TYPE_W-1:0]   event_type,
    output logic                               done,
    output logic                               removed_valid,
    output logic [smpq_pkg::TIME_W-1:0]        removed_time,
    output logic [smpq_pkg::JOB_W-1:0]         removed_job,
    output logic [smpq_pkg::TYPE_W-1:0]        removed_type,
    output logic [1:0]                         error_code,
    output logic [smpq_pkg::OCC_W-1:0]         occupancy
);
    smpq_pkg::cmd_t  cmd;
    smpq_pkg::stat_t stat;

    smpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    smpq_dp #(.DEPTH(DEPTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .event_time    (event_time),
        .job_number    (job_number),
        .event_type    (event_type),
        .cmd           (cmd),
        .stat          (stat),
        .removed_valid (removed_valid),
        .removed_time  (removed_time),
        .removed_job   (removed_job),
        .removed_type  (removed_type),
        .error_code    (error_code),
        .occupancy     (occupancy),
        .done          (done)
    );
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the stable minimum priority queue.
// Predicts each result with a sorted local store and compares it against the done strobe.
// Depends on smpq_pkg and stable_min_priority_queue.
`timescale 1ns / 1ps
module testbench;
    import smpq_pkg::*;

    localparam int QDEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   tm;
        logic [JOB_W-1:0]    job;
        logic [TYPE_W-1:0]   kind;
        logic [1:0]          err;
        logic [OCC_W-1:0]    occ;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic operation;
    logic [TIME_W-1:0] event_time;
    logic [JOB_W-1:0] job_number;
    logic [TYPE_W-1:0] event_type;
    logic done;
    logic removed_valid;
    logic [TIME_W-1:0] removed_time;
    logic [JOB_W-1:0] removed_job;
    logic [TYPE_W-1:0] removed_type;
    logic [1:0] error_code;
    logic [OCC_W-1:0] occupancy;

    logic [TIME_W-1:0] sorted_time [QDEPTH];
    logic [JOB_W-1:0] sorted_job [QDEPTH];
    logic [TYPE_W-1:0] sorted_kind [QDEPTH];
    int stored;
    outcome_t pending_outcomes [$];
    int failures;
    int cycles;
    bit random_gaps;

    stable_min_priority_queue uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .event_time(event_time), .job_number(job_number),
        .event_type(event_type), .done(done), .removed_valid(removed_valid),
        .removed_time(removed_time), .removed_job(removed_job),
        .removed_type(removed_type), .error_code(error_code), .occupancy(occupancy)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic outcome_t predict_queue(input logic op, input logic [TIME_W-1:0] t,
                                               input logic [JOB_W-1:0] j,
                                               input logic [TYPE_W-1:0] ty);
        outcome_t r;
        int pos;
        r = '0;
        if (op == OP_INSERT)
        begin
            if (stored >= QDEPTH)
                r.err = ERR_FULL;
            else
            begin
                pos = 0;
                while (pos < stored && sorted_time[pos] <= t)
                    pos++;
                for (int k = stored; k > pos; k--)
                begin
                    sorted_time[k] = sorted_time[k-1];
                    sorted_job[k] = sorted_job[k-1];
                    sorted_kind[k] = sorted_kind[k-1];
                end
                sorted_time[pos] = t;
                sorted_job[pos] = j;
                sorted_kind[pos] = ty;
                stored++;
                r.err = ERR_OK;
            end
        end
        else if (stored == 0)
            r.err = ERR_EMPTY;
        else
        begin
            r.valid = 1'b1;
            r.tm = sorted_time[0];
            r.job = sorted_job[0];
            r.kind = sorted_kind[0];
            for (int k = 1; k < stored; k++)
            begin
                sorted_time[k-1] = sorted_time[k];
                sorted_job[k-1] = sorted_job[k];
                sorted_kind[k-1] = sorted_kind[k];
            end
            stored--;
            r.err = ERR_OK;
        end
        r.occ = stored[OCC_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [TIME_W-1:0] t,
                             input logic [JOB_W-1:0] j, input logic [TYPE_W-1:0] ty);
        int gap;
        gap = random_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        event_time <= t;
        job_number <= j;
        event_type <= ty;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(predict_queue(op, t, j, ty));
    endtask

    task automatic drain_queue();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_and_full();
        send_item(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        for (int i = 0; i < QDEPTH + 2; i++)
            send_item(OP_INSERT, (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i % 4),
                      16'(i), 8'(255 - i));
        send_item(OP_INSERT, 32'h0, 16'hFFFF, 8'hFF);
        drain_queue();
        for (int i = 0; i < QDEPTH + 1; i++)
            send_item(OP_REMOVE, 32'h0, 16'h0, 8'h0);
    endtask

    task automatic test_equal_times();
        for (int i = 0; i < 4; i++)
            send_item(OP_INSERT, 32'h8000_0000, 16'(16'hA000 + i), 8'(i));
        for (int i = 0; i < 4; i++)
            send_item(OP_REMOVE, 32'h0, 16'h0, 8'h0);
    endtask

    task automatic test_random_traffic(input int count);
        logic op;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < count; i++)
        begin
            random_gaps = (i % 200) < 150;
            op = ($urandom_range(0, 99) < (stored < QDEPTH / 2 ? 35 : 60)) ? OP_REMOVE
                                                                            : OP_INSERT;
            t = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 7)) : 32'($urandom);
            send_item(op, t, 16'($urandom), 8'($urandom));
            if (i == count / 2)
                drain_queue();
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual time %h", $time,
                         removed_time);
                failures++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (removed_valid !== want.valid || removed_time !== want.tm
                    || removed_job !== want.job || removed_type !== want.kind
                    || error_code !== want.err || occupancy !== want.occ)
                begin
                    $display("%0t: mismatch, exp %b %h %h %h %0d %0d, act %b %h %h %h %0d %0d",
                             $time, want.valid, want.tm, want.job, want.kind, want.err,
                             want.occ, removed_valid, removed_time, removed_job,
                             removed_type, error_code, occupancy);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = 1'b0;
        event_time = '0;
        job_number = '0;
        event_type = '0;
        stored = 0;
        failures = 0;
        cycles = 0;
        random_gaps = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_full();
        test_equal_times();
        test_random_traffic(1250);
        drain_queue();
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
